// File: rtl/hls_pkg.sv
`timescale 1ns / 1ps

package hls_pkg;

  // Fixed field widths
  localparam int PIX_W   = 32;
  localparam int LEN_W   = 12;
  localparam int CFG_IDX_W = 2;

  // Defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_RATIO_DEF = 4;

  // Hard cap on outputs produced from one source pixel
  localparam int RESULT_LIMIT = 8;

  // Depth of the job queue between sequencer and blender
  localparam int QUEUE_DEPTH = 4;

  // Weight divider produces 256ths; 32ths are the top five bits
  localparam int WEIGHT_W = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE = 2'd2;

  // Reset values of the registers
  localparam logic [LEN_W-1:0] OUT_WIDTH_RST = 12'd640;
  localparam logic [LEN_W-1:0] IN_WIDTH_RST  = 12'd512;

  // Pixel packing
  localparam logic MODE_XRGB   = 1'b0;
  localparam logic MODE_RGB565 = 1'b1;

  // One output pixel's worth of work for the blender
  typedef struct packed {
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] right;
    logic [LEN_W-1:0] phase;
    logic             last;
  } hls_job_t;

endpackage

// File: rtl/hls_front.sv
`timescale 1ns / 1ps

module hls_front
  import hls_pkg::*;
#(
  parameter int MAX_RATIO = MAX_RATIO_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [LEN_W-1:0] out_len_i,
  input  logic [LEN_W-1:0] in_len_i,
  input  logic             src_valid_i,
  output logic             src_ready_o,
  input  logic [PIX_W-1:0] src_pixel_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output hls_job_t         push_job_o
);

  localparam int CAP   = (2 * MAX_RATIO < RESULT_LIMIT) ? 2 * MAX_RATIO : RESULT_LIMIT;
  localparam int CNT_W = $clog2(CAP + 1);

  typedef enum logic [1:0] {
    FS_WAIT = 2'b01,
    FS_GEN  = 2'b10
  } front_state_e;

  front_state_e     state_q, state_d;
  logic [PIX_W-1:0] left_q, left_d;
  logic [PIX_W-1:0] right_q, right_d;
  logic [LEN_W-1:0] phase_q, phase_d;
  logic [LEN_W-1:0] out_index_q, out_index_d;
  logic [LEN_W-1:0] in_index_q, in_index_d;
  logic             primed_q, primed_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [LEN_W-1:0] out_nxt;
  logic             last;
  logic [LEN_W:0]   phase_sum;
  logic [LEN_W:0]   phase_wrap;
  logic             cap_hit;

  assign out_nxt    = out_index_q + LEN_W'(1);
  assign last       = (out_nxt >= out_len_i);
  assign phase_sum  = {1'b0, phase_q} + {1'b0, in_len_i};
  assign phase_wrap = phase_sum - {1'b0, out_len_i};
  assign cap_hit    = (cnt_q >= CNT_W'(CAP));

  assign src_ready_o  = (state_q == FS_WAIT);
  assign push_valid_o = (state_q == FS_GEN) && !cap_hit;
  assign push_job_o   = '{left: left_q, right: right_q, phase: phase_q, last: last};

  // Phase and pixel-pair sequencer
  always_comb begin
    state_d     = state_q;
    left_d      = left_q;
    right_d     = right_q;
    phase_d     = phase_q;
    out_index_d = out_index_q;
    in_index_d  = in_index_q;
    primed_d    = primed_q;
    cnt_d       = cnt_q;
    unique case (state_q)
      FS_WAIT: begin
        if (src_valid_i) begin
          cnt_d = '0;
          if (!primed_q) begin
            // first pixel of a line fills both sides of the pair
            primed_d    = 1'b1;
            left_d      = src_pixel_i;
            right_d     = src_pixel_i;
            phase_d     = '0;
            out_index_d = '0;
            in_index_d  = LEN_W'(1);
            if (in_len_i <= LEN_W'(1)) begin
              state_d = FS_GEN;
            end
          end else begin
            // surplus pixels past the line width are dropped
            if (in_index_q < in_len_i) begin
              right_d    = src_pixel_i;
              in_index_d = in_index_q + LEN_W'(1);
            end
            state_d = FS_GEN;
          end
        end
      end
      FS_GEN: begin
        if (cap_hit) begin
          // too many outputs for one pixel: skip rest of interval
          phase_d = '0;
          left_d  = right_q;
          state_d = FS_WAIT;
        end else if (push_ready_i) begin
          cnt_d       = cnt_q + CNT_W'(1);
          out_index_d = out_nxt;
          if (last) begin
            phase_d     = '0;
            out_index_d = '0;
            in_index_d  = '0;
            primed_d    = 1'b0;
            state_d     = FS_WAIT;
          end else if (phase_sum >= {1'b0, out_len_i}) begin
            // step pair; past the line end the last pixel repeats
            phase_d = (phase_wrap >= {1'b0, out_len_i}) ? out_len_i - LEN_W'(1)
                                                        : phase_wrap[LEN_W-1:0];
            left_d  = right_q;
            if (in_index_q < in_len_i) begin
              state_d = FS_WAIT;
            end
          end else begin
            phase_d = phase_sum[LEN_W-1:0];
          end
        end
      end
      default: state_d = FS_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FS_WAIT;
      left_q      <= '0;
      right_q     <= '0;
      phase_q     <= '0;
      out_index_q <= '0;
      in_index_q  <= '0;
      primed_q    <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      left_q      <= left_d;
      right_q     <= right_d;
      phase_q     <= phase_d;
      out_index_q <= out_index_d;
      in_index_q  <= in_index_d;
      primed_q    <= primed_d;
      cnt_q       <= cnt_d;
    end
  end

endmodule

// File: rtl/hls_queue.sv
`timescale 1ns / 1ps

module hls_queue
  import hls_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  hls_job_t push_job_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output hls_job_t pop_job_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  hls_job_t         slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             push, pop;

  assign push_ready_o = (fill_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_job_o    = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer wrap works for any depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      fill_d = fill_q + CNT_W'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Job storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// File: rtl/hls_back.sv
`timescale 1ns / 1ps

module hls_back
  import hls_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [LEN_W-1:0] out_len_i,
  input  logic             pixel_mode_i,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  hls_job_t         pop_job_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [PIX_W-1:0] out_pixel_o,
  output logic             line_end_o
);

  localparam int STEP_W = $clog2(WEIGHT_W);

  typedef enum logic [2:0] {
    BS_IDLE  = 3'b001,
    BS_DIV   = 3'b010,
    BS_BLEND = 3'b100
  } back_state_e;

  back_state_e         state_q, state_d;
  hls_job_t            job_q, job_d;
  logic [LEN_W-1:0]    rem_q, rem_d;
  logic [WEIGHT_W-1:0] quo_q, quo_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                out_valid_q, out_valid_d;
  logic [PIX_W-1:0]    out_pixel_q, out_pixel_d;
  logic                line_end_q, line_end_d;

  logic [LEN_W:0]      rem_dbl;
  logic                sub_ok;
  logic [LEN_W-1:0]    ph_lim;
  logic                out_free;
  logic [8:0]          wq, wp;
  logic [PIX_W-1:0]    blended;

  // One channel: (a*p + b*q) / r, r = 32 or 256
  function automatic logic [7:0] blend_ch(input logic [7:0] ca, input logic [7:0] cb,
                                          input logic [8:0] p, input logic [8:0] q,
                                          input logic mode);
    logic [17:0] sum;
    sum = 18'(ca) * 18'(p) + 18'(cb) * 18'(q);
    return (mode == MODE_RGB565) ? sum[12:5] : sum[15:8];
  endfunction

  assign rem_dbl  = {rem_q, 1'b0};
  assign sub_ok   = (rem_dbl >= {1'b0, out_len_i});
  assign ph_lim   = (pop_job_i.phase >= out_len_i) ? out_len_i - LEN_W'(1) : pop_job_i.phase;
  assign out_free = !out_valid_q || out_ready_i;

  assign pop_ready_o = (state_q == BS_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_pixel_q;
  assign line_end_o  = line_end_q;

  // Weights from the quotient of 256ths
  always_comb begin
    if (pixel_mode_i == MODE_RGB565) begin
      wq = {4'b0, quo_q[7:3]};
      wp = 9'd32 - wq;
    end else begin
      wq = {1'b0, quo_q};
      wp = 9'd256 - wq;
    end
  end

  // Per-channel blend; alpha is dropped in 32-bit mode
  always_comb begin
    logic [7:0] c0, c1, c2;
    if (pixel_mode_i == MODE_RGB565) begin
      c0 = blend_ch({3'b0, job_q.left[4:0]}, {3'b0, job_q.right[4:0]}, wp, wq, pixel_mode_i);
      c1 = blend_ch({2'b0, job_q.left[10:5]}, {2'b0, job_q.right[10:5]}, wp, wq,
                    pixel_mode_i);
      c2 = blend_ch({3'b0, job_q.left[15:11]}, {3'b0, job_q.right[15:11]}, wp, wq,
                    pixel_mode_i);
      blended = {16'b0, c2[4:0], c1[5:0], c0[4:0]};
    end else begin
      c0 = blend_ch(job_q.left[7:0], job_q.right[7:0], wp, wq, pixel_mode_i);
      c1 = blend_ch(job_q.left[15:8], job_q.right[15:8], wp, wq, pixel_mode_i);
      c2 = blend_ch(job_q.left[23:16], job_q.right[23:16], wp, wq, pixel_mode_i);
      blended = {8'b0, c2, c1, c0};
    end
  end

  // Job fetch, bit-serial weight divider, blend into output register
  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_pixel_d = out_pixel_q;
    line_end_d  = line_end_q;
    unique case (state_q)
      BS_IDLE: begin
        if (pop_valid_i) begin
          job_d   = pop_job_i;
          rem_d   = ph_lim;
          quo_d   = '0;
          step_d  = '0;
          state_d = BS_DIV;
        end
      end
      BS_DIV: begin
        // restoring step: one quotient bit of 256*phase/out_len
        rem_d  = sub_ok ? LEN_W'(rem_dbl - {1'b0, out_len_i}) : rem_dbl[LEN_W-1:0];
        quo_d  = {quo_q[WEIGHT_W-2:0], sub_ok};
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(WEIGHT_W - 1)) begin
          state_d = BS_BLEND;
        end
      end
      BS_BLEND: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pixel_d = blended;
          line_end_d  = job_q.last;
          state_d     = BS_IDLE;
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q       <= job_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    out_pixel_q <= out_pixel_d;
    line_end_q  <= line_end_d;
  end

endmodule

// File: rtl/horizontal_line_stretch_core.sv
// Back end: every output pixel takes a job fetch, the 8-step bit-serial
// weight divider and a blend; the next job is fetched only once the blend
// has reached the output register, which can stall it. Source pixels are
// taken as soon as the sequencer has queued all outputs of the previous pair.
// Reset: asynchronous, active low; registers return to 640 / 512 / xRGB and
// the line state clears so the next pixel primes a new line.
`timescale 1ns / 1ps

module horizontal_line_stretch_core
  import hls_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int MAX_RATIO = MAX_RATIO_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [LEN_W-1:0]     cfg_data_i,
  input  logic                 src_valid_i,
  output logic                 src_ready_o,
  input  logic [PIX_W-1:0]     src_pixel_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [PIX_W-1:0]     out_pixel_o,
  output logic                 line_end_o
);

  logic [LEN_W-1:0] out_width_q, out_width_d;
  logic [LEN_W-1:0] in_width_q, in_width_d;
  logic             pixel_mode_q, pixel_mode_d;
  logic [LEN_W-1:0] out_len, in_len;

  logic     push_valid, push_ready;
  hls_job_t push_job;
  logic     pop_valid, pop_ready;
  hls_job_t pop_job;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
    if (v == '0) begin
      return LEN_W'(1);
    end else if (int'(v) > MAX_WIDTH) begin
      return LEN_W'(MAX_WIDTH);
    end else begin
      return v;
    end
  endfunction

  assign cfg_ready_o = 1'b1;
  assign out_len     = eff_len(out_width_q);
  assign in_len      = eff_len(in_width_q);

  // Configuration registers; unknown indexes are ignored
  always_comb begin
    out_width_d  = out_width_q;
    in_width_d   = in_width_q;
    pixel_mode_d = pixel_mode_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_OUT_WIDTH:  out_width_d  = cfg_data_i;
        REG_IN_WIDTH:   in_width_d   = cfg_data_i;
        REG_PIXEL_MODE: pixel_mode_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_width_q  <= OUT_WIDTH_RST;
      in_width_q   <= IN_WIDTH_RST;
      pixel_mode_q <= MODE_XRGB;
    end else begin
      out_width_q  <= out_width_d;
      in_width_q   <= in_width_d;
      pixel_mode_q <= pixel_mode_d;
    end
  end

  hls_front #(
    .MAX_RATIO (MAX_RATIO)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .out_len_i    (out_len),
    .in_len_i     (in_len),
    .src_valid_i  (src_valid_i),
    .src_ready_o  (src_ready_o),
    .src_pixel_i  (src_pixel_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  hls_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  hls_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .out_len_i    (out_len),
    .pixel_mode_i (pixel_mode_q),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_job_i    (pop_job),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_pixel_o  (out_pixel_o),
    .line_end_o   (line_end_o)
  );

endmodule

// File: sim/horizontal_line_stretch_core_test.sv
`timescale 1ns / 1ps

module horizontal_line_stretch_core_test
  import hls_pkg::*;
();

  localparam int CLK_HALF      = 4;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_ITEMS  = 270;
  localparam int CALM_ITEMS    = 80;
  localparam int IDLE_PCT      = 33;
  localparam int PAIR_CAP      = (2 * MAX_RATIO_DEF < RESULT_LIMIT) ?
                                 2 * MAX_RATIO_DEF : RESULT_LIMIT;
  // No register lives at this index; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic [PIX_W-1:0] pixel;
    logic             line_end;
  } stretch_out_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [LEN_W-1:0]     cfg_data_i;
  logic                 src_valid_i;
  logic                 src_ready_o;
  logic [PIX_W-1:0]     src_pixel_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [PIX_W-1:0]     out_pixel_o;
  logic                 line_end_o;

  // Predictor copy of the registers and line state
  logic [LEN_W-1:0] cfg_out_w = OUT_WIDTH_RST;
  logic [LEN_W-1:0] cfg_in_w  = IN_WIDTH_RST;
  logic             cfg_mode  = MODE_XRGB;
  logic [PIX_W-1:0] pair_left    = '0;
  logic [PIX_W-1:0] pair_right   = '0;
  int unsigned      acc_phase    = 0;
  int unsigned      out_count    = 0;
  int unsigned      in_count     = 0;
  bit               line_started = 1'b0;

  stretch_out_t pending_pixels[$];
  stretch_out_t head_pixel;

  int unsigned errors       = 0;
  int unsigned items_sent   = 0;
  int unsigned pixels_seen  = 0;
  int unsigned reg_writes   = 0;
  int unsigned cycle_count  = 0;
  bit          src_idle_en  = 1'b1;
  bit          out_stall_en = 1'b1;

  horizontal_line_stretch_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .src_valid_i (src_valid_i),
    .src_ready_o (src_ready_o),
    .src_pixel_i (src_pixel_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_pixel_o (out_pixel_o),
    .line_end_o  (line_end_o)
  );

  // Clock
  initial clk_i = 1'b0;
  always #CLK_HALF clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d output pixels still pending", $time, pending_pixels.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Sink back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= out_stall_en ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
  end

  // Zero or oversize widths are clamped
  function automatic int unsigned eff_width(input logic [LEN_W-1:0] w);
    if (w == 0) return 1;
    if (w > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return int'(w);
  endfunction

  // Weighted mix of two pixels on packed channel masks
  function automatic logic [PIX_W-1:0] blend_pixels(input logic [PIX_W-1:0] a_px,
                                                    input logic [PIX_W-1:0] b_px,
                                                    input int unsigned ph,
                                                    input int unsigned ow);
    logic [63:0] scale, mask_lo, mask_hi, wq, wp, a_w, b_w, lo, hi;
    int unsigned ph_c;
    if (cfg_mode == MODE_RGB565) begin
      scale   = 64'd32;
      mask_lo = 64'h0000_f81f;
      mask_hi = 64'h0000_07e0;
      a_w     = {48'b0, a_px[15:0]};
      b_w     = {48'b0, b_px[15:0]};
    end else begin
      scale   = 64'd256;
      mask_lo = 64'h00ff_00ff;
      mask_hi = 64'h0000_ff00;
      a_w     = {32'b0, a_px};
      b_w     = {32'b0, b_px};
    end
    ph_c = (ph >= ow) ? ow - 1 : ph;
    wq = (scale * 64'(ph_c)) / 64'(ow);
    wp = scale - wq;
    lo = (((a_w & mask_lo) * wp + (b_w & mask_lo) * wq) / scale) & mask_lo;
    hi = (((a_w & mask_hi) * wp + (b_w & mask_hi) * wq) / scale) & mask_hi;
    return 32'(lo | hi);
  endfunction

  // Advance the line state by one source pixel and queue the pixels it yields
  function automatic void predict_stretch(input logic [PIX_W-1:0] px);
    int unsigned ow, iw, n;
    bit done;
    stretch_out_t item;
    ow = eff_width(cfg_out_w);
    iw = eff_width(cfg_in_w);
    n = 0;
    done = 1'b0;
    if (!line_started) begin
      line_started = 1'b1;
      pair_left  = px;
      pair_right = px;
      acc_phase  = 0;
      out_count  = 0;
      in_count   = 1;
      if (in_count < iw) return;
    end else if (in_count < iw) begin
      pair_right = px;
      in_count++;
    end
    while (!done) begin
      if (n >= PAIR_CAP) begin
        // cap hit inside an interval: skip the rest of it
        acc_phase = 0;
        pair_left = pair_right;
        done = 1'b1;
      end else begin
        item.pixel = blend_pixels(pair_left, pair_right, acc_phase, ow);
        out_count = (out_count + 1) & 12'hfff;
        item.line_end = (out_count >= ow);
        pending_pixels.push_back(item);
        n++;
        if (item.line_end) begin
          acc_phase    = 0;
          out_count    = 0;
          in_count     = 0;
          line_started = 1'b0;
          done = 1'b1;
        end else begin
          acc_phase += iw;
          if (acc_phase >= ow) begin
            acc_phase -= ow;
            if (acc_phase >= ow) acc_phase = ow - 1;
            pair_left = pair_right;
            if (in_count < iw) done = 1'b1;
          end
        end
      end
    end
  endfunction

  // Output checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected output pixel, expected none, got %h line_end %b",
                 $time, out_pixel_o, line_end_o);
      end else begin
        head_pixel = pending_pixels.pop_front();
        pixels_seen++;
        if (out_pixel_o !== head_pixel.pixel) begin
          errors++;
          $display("%0t: out_pixel expected %h, got %h", $time, head_pixel.pixel, out_pixel_o);
        end
        if (line_end_o !== head_pixel.line_end) begin
          errors++;
          $display("%0t: line_end expected %b, got %b", $time, head_pixel.line_end,
                   line_end_o);
        end
      end
    end
  end

  // Send one source pixel, with an optional idle gap in front
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    int unsigned gap;
    gap = 0;
    if (src_idle_en && $urandom_range(0, 99) < IDLE_PCT) gap = $urandom_range(1, 2);
    repeat (gap) begin
      @(negedge clk_i);
      src_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    src_valid_i <= 1'b1;
    src_pixel_i <= px;
    @(posedge clk_i);
    while (!src_ready_o) @(posedge clk_i);
    predict_stretch(px);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_OUT_WIDTH:  cfg_out_w = val;
      REG_IN_WIDTH:   cfg_in_w  = val;
      REG_PIXEL_MODE: cfg_mode  = val[0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait for all queued pixels, then let a priming item settle
  task automatic settle();
    @(negedge clk_i);
    src_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Finish whatever line is open with a one-pixel line
  task automatic close_line();
    write_reg(REG_IN_WIDTH, 12'd1);
    write_reg(REG_OUT_WIDTH, 12'd1);
    send_pixel($urandom);
    settle();
  endtask

  task automatic test_default_config();
    send_pixel(32'h0000_0000);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h00ff_00ff);
    settle();
  endtask

  // One-pixel source lines, including a short line after reconfiguration
  task automatic test_single_source_line();
    write_reg(REG_IN_WIDTH, 12'd1);
    write_reg(REG_OUT_WIDTH, 12'd4);
    send_pixel(32'hff00_ff00);
    send_pixel(32'h1234_5678);
    settle();
    write_reg(REG_IN_WIDTH, 12'd0);
    write_reg(REG_OUT_WIDTH, 12'd0);
    send_pixel(32'hffff_ffff);
    settle();
  endtask

  task automatic test_rgb565_line();
    close_line();
    write_reg(REG_PIXEL_MODE, 12'h001);
    write_reg(REG_IN_WIDTH, 12'd4);
    write_reg(REG_OUT_WIDTH, 12'd13);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h0000_0000);
    send_pixel(32'h5a5a_f800);
    send_pixel(32'ha5a5_07e0);
    send_pixel(32'h0000_001f);
    settle();
    // upper data bits set, mode bit clear
    write_reg(REG_PIXEL_MODE, 12'hffe);
  endtask

  task automatic test_width_extremes();
    write_reg(REG_OUT_WIDTH, 12'hfff);
    write_reg(REG_IN_WIDTH, 12'd2048);
    send_pixel(32'h8000_0001);
    send_pixel(32'h7fff_fffe);
    send_pixel($urandom);
    settle();
    write_reg(REG_OUT_WIDTH, 12'd2048);
    write_reg(REG_IN_WIDTH, 12'd512);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h0000_0000);
    send_pixel($urandom);
    settle();
  endtask

  // Ratios outside the supported range: result cap, surplus input, phase overrun
  task automatic test_out_of_range();
    close_line();
    write_reg(REG_IN_WIDTH, 12'd2);
    write_reg(REG_OUT_WIDTH, 12'd19);
    repeat (4) send_pixel($urandom);
    settle();
    write_reg(REG_IN_WIDTH, 12'd5);
    write_reg(REG_OUT_WIDTH, 12'd3);
    repeat (3) send_pixel($urandom);
    settle();
    write_reg(REG_SPARE, 12'($urandom_range(0, 4095)));
  endtask

  task automatic test_random_lines();
    int unsigned target, calm_end, sel, iw, ow, count;
    target   = items_sent + RANDOM_ITEMS;
    calm_end = items_sent + CALM_ITEMS;
    src_idle_en  = 1'b0;
    out_stall_en = 1'b0;
    while (items_sent < target) begin
      if (items_sent >= calm_end) begin
        src_idle_en  = 1'b1;
        out_stall_en = 1'b1;
      end
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        iw = $urandom_range(1, 12);
        ow = $urandom_range(iw, MAX_RATIO_DEF * iw);
      end else if (sel < 92) begin
        iw = $urandom_range(0, 20);
        ow = $urandom_range(0, 40);
      end else begin
        iw = $urandom_range(1024, MAX_WIDTH_DEF);
        ow = $urandom_range(iw, 4095);
      end
      write_reg(REG_IN_WIDTH, 12'(iw));
      write_reg(REG_OUT_WIDTH, 12'(ow));
      write_reg(REG_PIXEL_MODE, 12'($urandom_range(0, 4095)));
      if (sel >= 92) begin
        count = $urandom_range(2, 8);
      end else if ($urandom_range(0, 99) < 15) begin
        // ragged: stop part-way or spill into the next line
        count = $urandom_range(1, eff_width(12'(iw)) + 2);
      end else begin
        count = $urandom_range(1, 3) * eff_width(12'(iw));
      end
      repeat (count) send_pixel($urandom);
      settle();
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_OUT_WIDTH;
    cfg_data_i  = '0;
    src_valid_i = 1'b0;
    src_pixel_i = '0;
    out_ready_i = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_config();
    test_single_source_line();
    test_rgb565_line();
    test_width_extremes();
    test_out_of_range();
    test_random_lines();
    settle();

    $display("Covered %0d source items and %0d register writes: both pixel modes,",
             items_sent, reg_writes);
    $display("clamped and out-of-range widths; %0d output pixels checked", pixels_seen);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/hls_pkg.sv
rtl/hls_front.sv
rtl/hls_queue.sv
rtl/hls_back.sv
rtl/horizontal_line_stretch_core.sv
sim/horizontal_line_stretch_core_test.sv
